// ===== design/rotate_project_point_top_defines.svh =====
// Assertion macros shared by the rotate and project design files.
`ifndef ROTATE_PROJECT_POINT_TOP_DEFINES_SVH
`define ROTATE_PROJECT_POINT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rpp_pkg.sv =====
// Package with the shared types, constants and helper functions of the projector.
`timescale 1ns / 1ps

package rpp_pkg;

    localparam int COORD_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int TRIG_W   = 16;
    localparam int FOCAL_W  = 12;
    localparam int OFFSET_W = 15;

    localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = 12'd500;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 15'd20480;

    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;

    localparam int CORDIC_STAGES = 16;
    localparam int CW            = 18;
    localparam logic signed [CW-1:0] CORDIC_X0 = 18'sd19898;

    localparam int QUEUE_DEPTH = 4;

    localparam int ROT_W   = 18;
    localparam int PROD_W  = 34;
    localparam int DEPTH_W = 19;
    localparam int NUM_W   = 31;
    localparam int DIVN_W  = 30;
    localparam int DIVD_W  = 19;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FOCAL  = 8'd0,
        REG_OFFSET = 8'd1
    } cfg_reg_t;

    // Point plus sine and cosine for the X, Y and Z angles (lane 0 is X).
    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [2:0][TRIG_W-1:0]    sn;
        logic [2:0][TRIG_W-1:0]    cs;
    } rpp_item_t;

    function automatic logic signed [CW-1:0] atan_phase(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0:       r = 18'sd8192;
            1:       r = 18'sd4836;
            2:       r = 18'sd2555;
            3:       r = 18'sd1297;
            4:       r = 18'sd651;
            5:       r = 18'sd326;
            6:       r = 18'sd163;
            7:       r = 18'sd81;
            8:       r = 18'sd41;
            9:       r = 18'sd20;
            10:      r = 18'sd10;
            11:      r = 18'sd5;
            12:      r = 18'sd3;
            13:      r = 18'sd1;
            14:      r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767)
            r = 16'sh7FFF;
        else if (v < -34'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Rounded sum of two Q15-scaled products, floor after adding one half.
    function automatic logic signed [ROT_W-1:0] mix_round(input logic signed [PROD_W-1:0] p0,
                                                          input logic signed [PROD_W-1:0] p1);
        logic signed [PROD_W:0] s;
        s = (PROD_W+1)'(p0) + (PROD_W+1)'(p1) + 35'sd16384;
        return s[ROT_W+14:15];
    endfunction

endpackage

// ===== design/rpp_front.sv =====
// Front end: accepts points and runs three pipelined CORDIC lanes for the angles.
`timescale 1ns / 1ps

module rpp_front import rpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic [ANGLE_W-1:0]        angle_x,
    input  logic [ANGLE_W-1:0]        angle_y,
    input  logic [ANGLE_W-1:0]        angle_z,
    input  logic                      queue_full,
    output logic                      out_valid,
    output rpp_item_t                 out_item
);

    logic en;
    logic [ANGLE_W-1:0] ang [0:2];
    logic [2:0]         flip;
    logic [ANGLE_W-1:0] folded [0:2];

    logic signed [CW-1:0]      x_reg [0:CORDIC_STAGES][0:2];
    logic signed [CW-1:0]      y_reg [0:CORDIC_STAGES][0:2];
    logic signed [CW-1:0]      z_reg [0:CORDIC_STAGES][0:2];
    logic [2:0]                flip_reg [0:CORDIC_STAGES];
    logic signed [COORD_W-1:0] p_reg [0:CORDIC_STAGES][0:2];
    logic                      v_reg [0:CORDIC_STAGES];

    rpp_item_t item_reg, item_next;
    logic      valid_reg;

    assign en       = !queue_full;
    assign in_ready = en;

    assign ang[0] = angle_x;
    assign ang[1] = angle_y;
    assign ang[2] = angle_z;

    // Fold each angle into the right half plane; the results get negated back.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [ANGLE_W-1:0] q;
            q         = ang[l] + 16'h4000;
            flip[l]   = q[ANGLE_W-1];
            folded[l] = flip[l] ? (ang[l] + 16'h8000) : ang[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                x_reg[0][l] <= CORDIC_X0;
                y_reg[0][l] <= '0;
                z_reg[0][l] <= {{(CW-ANGLE_W){folded[l][ANGLE_W-1]}}, folded[l]};
            end
            flip_reg[0] <= flip;
            p_reg[0][0] <= point_x;
            p_reg[0][1] <= point_y;
            p_reg[0][2] <= point_z;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g+1] <= 1'b0;
            else if (en)
                v_reg[g+1] <= v_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (!z_reg[g][l][CW-1])
                    begin
                        x_reg[g+1][l] <= x_reg[g][l] - (y_reg[g][l] >>> g);
                        y_reg[g+1][l] <= y_reg[g][l] + (x_reg[g][l] >>> g);
                        z_reg[g+1][l] <= z_reg[g][l] - atan_phase(g);
                    end
                    else
                    begin
                        x_reg[g+1][l] <= x_reg[g][l] + (y_reg[g][l] >>> g);
                        y_reg[g+1][l] <= y_reg[g][l] - (x_reg[g][l] >>> g);
                        z_reg[g+1][l] <= z_reg[g][l] + atan_phase(g);
                    end
                    p_reg[g+1][l] <= p_reg[g][l];
                end
                flip_reg[g+1] <= flip_reg[g];
            end
        end
    end

    always_comb
    begin
        item_next    = item_reg;
        item_next.px = p_reg[CORDIC_STAGES][0];
        item_next.py = p_reg[CORDIC_STAGES][1];
        item_next.pz = p_reg[CORDIC_STAGES][2];
        for (int l = 0; l < 3; l++)
        begin
            logic signed [CW-1:0] cx, sy;
            cx = flip_reg[CORDIC_STAGES][l] ? -x_reg[CORDIC_STAGES][l] : x_reg[CORDIC_STAGES][l];
            sy = flip_reg[CORDIC_STAGES][l] ? -y_reg[CORDIC_STAGES][l] : y_reg[CORDIC_STAGES][l];
            item_next.cs[l] = sat16(PROD_W'(cx));
            item_next.sn[l] = sat16(PROD_W'(sy));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= v_reg[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/rpp_queue.sv =====
// Short queue that decouples the trig front end from the rotate and divide back end.
`timescale 1ns / 1ps

`include "rotate_project_point_top_defines.svh"

module rpp_queue import rpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  rpp_item_t push_item,
    output logic      full,
    output logic      pop_valid,
    input  logic      pop_ready,
    output rpp_item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rpp_item_t mem_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_reg];
    assign push      = push_valid && !full;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    `RPP_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `RPP_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "lost push")
    `RPP_ASSERT_NEXT(a_rd_moves, pop, rd_reg != $past(rd_reg), "pop did not advance")

endmodule

// ===== design/rpp_back.sv =====
// Back end: three rotations, depth offset, pipelined division and screen mapping.
`timescale 1ns / 1ps

module rpp_back import rpp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rpp_item_t                  in_item,
    input  logic [FOCAL_W-1:0]         focal_length,
    input  logic [OFFSET_W-1:0]        depth_offset,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_W-1:0]  screen_x,
    output logic signed [COORD_W-1:0]  screen_y,
    output logic                       zero_depth
);

    localparam int NSTG = 8 + DIVN_W;
    localparam logic signed [NUM_W+1:0] HALF_X = (NUM_W+2)'(SCREEN_WIDTH / 2);
    localparam logic signed [NUM_W+1:0] HALF_Y = (NUM_W+2)'(SCREEN_HEIGHT / 2);

    logic en;
    logic vld_reg [0:NSTG-1];

    // Rotation products and carried values.
    logic signed [PROD_W-1:0] p1_reg [0:3];
    logic signed [ROT_W-1:0]  x1_reg;
    logic [1:0][TRIG_W-1:0]   s1_reg, c1_reg;
    logic signed [ROT_W-1:0]  x2_reg, y2_reg, z2_reg;
    logic [1:0][TRIG_W-1:0]   s2_reg, c2_reg;
    logic signed [PROD_W-1:0] p3_reg [0:3];
    logic signed [ROT_W-1:0]  y3_reg;
    logic [TRIG_W-1:0]        s3_reg, c3_reg;
    logic signed [ROT_W-1:0]  x4_reg, y4_reg, z4_reg;
    logic [TRIG_W-1:0]        s4_reg, c4_reg;
    logic signed [PROD_W-1:0] p5_reg [0:3];
    logic signed [ROT_W-1:0]  z5_reg;
    logic signed [ROT_W-1:0]  x6_reg, y6_reg, z6_reg;

    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic                      zero_p_reg;

    logic [DIVD_W-1:0] rx_reg [0:DIVN_W];
    logic [DIVD_W-1:0] ry_reg [0:DIVN_W];
    logic [DIVN_W-1:0] qx_reg [0:DIVN_W];
    logic [DIVN_W-1:0] qy_reg [0:DIVN_W];
    logic [DIVD_W-1:0] d_reg  [0:DIVN_W];
    logic              negx_reg [0:DIVN_W];
    logic              negy_reg [0:DIVN_W];
    logic              zero_reg [0:DIVN_W];

    logic signed [COORD_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic                      zf_reg, valid_reg;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
                vld_reg[i] <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
                vld_reg[i] <= vld_reg[i-1];
            valid_reg <= vld_reg[NSTG-1];
        end
    end

    // Rotations about X, Y and Z: products in one stage, rounded sums in the next.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0] <= PROD_W'(in_item.py) * $signed(in_item.cs[0]);
            p1_reg[1] <= -(PROD_W'(in_item.pz) * $signed(in_item.sn[0]));
            p1_reg[2] <= PROD_W'(in_item.py) * $signed(in_item.sn[0]);
            p1_reg[3] <= PROD_W'(in_item.pz) * $signed(in_item.cs[0]);
            x1_reg    <= ROT_W'(in_item.px);
            s1_reg    <= in_item.sn[2:1];
            c1_reg    <= in_item.cs[2:1];

            x2_reg <= x1_reg;
            y2_reg <= mix_round(p1_reg[0], p1_reg[1]);
            z2_reg <= mix_round(p1_reg[2], p1_reg[3]);
            s2_reg <= s1_reg;
            c2_reg <= c1_reg;

            p3_reg[0] <= PROD_W'(x2_reg) * $signed(c2_reg[0]);
            p3_reg[1] <= PROD_W'(z2_reg) * $signed(s2_reg[0]);
            p3_reg[2] <= -(PROD_W'(x2_reg) * $signed(s2_reg[0]));
            p3_reg[3] <= PROD_W'(z2_reg) * $signed(c2_reg[0]);
            y3_reg    <= y2_reg;
            s3_reg    <= s2_reg[1];
            c3_reg    <= c2_reg[1];

            x4_reg <= mix_round(p3_reg[0], p3_reg[1]);
            z4_reg <= mix_round(p3_reg[2], p3_reg[3]);
            y4_reg <= y3_reg;
            s4_reg <= s3_reg;
            c4_reg <= c3_reg;

            p5_reg[0] <= PROD_W'(x4_reg) * $signed(c4_reg);
            p5_reg[1] <= -(PROD_W'(y4_reg) * $signed(s4_reg));
            p5_reg[2] <= PROD_W'(x4_reg) * $signed(s4_reg);
            p5_reg[3] <= PROD_W'(y4_reg) * $signed(c4_reg);
            z5_reg    <= z4_reg;

            x6_reg <= mix_round(p5_reg[0], p5_reg[1]);
            y6_reg <= mix_round(p5_reg[2], p5_reg[3]);
            z6_reg <= z5_reg;

            nx_reg     <= NUM_W'(x6_reg) * $signed({1'b0, focal_length});
            ny_reg     <= NUM_W'(y6_reg) * $signed({1'b0, focal_length});
            depth_reg  <= DEPTH_W'(z6_reg) + $signed(DEPTH_W'(depth_offset));
            zero_p_reg <= (DEPTH_W'(z6_reg) + $signed(DEPTH_W'(depth_offset))) == '0;
        end
    end

    // Divider setup on magnitudes; the sign is put back after the last step.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic signed [NUM_W-1:0]   ax, ay;
            logic signed [DEPTH_W-1:0] ad;
            ax = nx_reg[NUM_W-1] ? -nx_reg : nx_reg;
            ay = ny_reg[NUM_W-1] ? -ny_reg : ny_reg;
            ad = depth_reg[DEPTH_W-1] ? -depth_reg : depth_reg;
            rx_reg[0]   <= '0;
            ry_reg[0]   <= '0;
            qx_reg[0]   <= ax[DIVN_W-1:0];
            qy_reg[0]   <= ay[DIVN_W-1:0];
            d_reg[0]    <= ad;
            negx_reg[0] <= nx_reg[NUM_W-1] ^ depth_reg[DEPTH_W-1];
            negy_reg[0] <= ny_reg[NUM_W-1] ^ depth_reg[DEPTH_W-1];
            zero_reg[0] <= zero_p_reg;
        end
    end

    // One restoring quotient bit per stage for both coordinates.
    for (genvar k = 0; k < DIVN_W; k++)
    begin : g_div
        logic [DIVD_W:0] tx, ty;
        assign tx = {rx_reg[k], qx_reg[k][DIVN_W-1]};
        assign ty = {ry_reg[k], qy_reg[k][DIVN_W-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (tx >= {1'b0, d_reg[k]})
                begin
                    rx_reg[k+1] <= DIVD_W'(tx - {1'b0, d_reg[k]});
                    qx_reg[k+1] <= {qx_reg[k][DIVN_W-2:0], 1'b1};
                end
                else
                begin
                    rx_reg[k+1] <= tx[DIVD_W-1:0];
                    qx_reg[k+1] <= {qx_reg[k][DIVN_W-2:0], 1'b0};
                end
                if (ty >= {1'b0, d_reg[k]})
                begin
                    ry_reg[k+1] <= DIVD_W'(ty - {1'b0, d_reg[k]});
                    qy_reg[k+1] <= {qy_reg[k][DIVN_W-2:0], 1'b1};
                end
                else
                begin
                    ry_reg[k+1] <= ty[DIVD_W-1:0];
                    qy_reg[k+1] <= {qy_reg[k][DIVN_W-2:0], 1'b0};
                end
                d_reg[k+1]    <= d_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    always_comb
    begin
        logic signed [NUM_W+1:0] qx, qy;
        qx = $signed({3'b000, qx_reg[DIVN_W]});
        qy = $signed({3'b000, qy_reg[DIVN_W]});
        if (negx_reg[DIVN_W])
            qx = -qx;
        if (negy_reg[DIVN_W])
            qy = -qy;
        sx_next = sat16(PROD_W'(qx + HALF_X));
        sy_next = sat16(PROD_W'(qy + HALF_Y));
        if (zero_reg[DIVN_W])
        begin
            sx_next = '0;
            sy_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            zf_reg <= zero_reg[DIVN_W];
        end
    end

    assign out_valid  = valid_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign zero_depth = zf_reg;

endmodule

// ===== design/rotate_project_point_top.sv =====
// Path: a point goes through the CORDIC front end, then the queue (write, then read),
// then the back end. Throughput: one point per cycle while neither end stalls;
// the 16-step CORDIC and 30-step divider are fully pipelined.
// Either end stalls alone; the four-entry queue absorbs the difference.
// Reset: rst_n clears all valid flags and queue pointers and loads focal length 500
// and depth offset 20480; no clearing pass is needed.
`timescale 1ns / 1ps

`include "rotate_project_point_top_defines.svh"

module rotate_project_point_top import rpp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_x, point_y, point_z, angle_x, angle_y, angle_z (16 bits each)
    input  logic [95:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // screen_x, screen_y (16 bits each)
    output logic [31:0]            m_tdata,
    // zero_depth
    output logic [0:0]             m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [FOCAL_W-1:0]  focal_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic      f_valid, q_full, q_valid, b_ready;
    rpp_item_t f_item, q_item;
    logic signed [COORD_W-1:0] screen_x, screen_y;
    logic      zero_depth;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= FOCAL_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FOCAL:  focal_reg  <= cfg_data[FOCAL_W-1:0];
                REG_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                default:    ;
            endcase
        end
    end

    rpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .point_x    (s_tdata[15:0]),
        .point_y    (s_tdata[31:16]),
        .point_z    (s_tdata[47:32]),
        .angle_x    (s_tdata[63:48]),
        .angle_y    (s_tdata[79:64]),
        .angle_z    (s_tdata[95:80]),
        .queue_full (q_full),
        .out_valid  (f_valid),
        .out_item   (f_item)
    );

    rpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_item  (f_item),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_ready  (b_ready),
        .pop_item   (q_item)
    );

    rpp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_ready     (b_ready),
        .in_item      (q_item),
        .focal_length (focal_reg),
        .depth_offset (offset_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .zero_depth   (zero_depth)
    );

    assign m_tdata = {screen_y, screen_x};
    assign m_tuser = zero_depth;

    `RPP_ASSERT_IMPL(a_zero_depth_out, m_tvalid && m_tuser[0], m_tdata == 32'd0, "zero depth coords")

endmodule

// ===== test/tb_rotate_project_point_top.sv =====
// Self-checking testbench for the rotate and project point pipeline.
`timescale 1ns / 1ps

module tb_rotate_project_point_top;
    import rpp_pkg::*;

    localparam int HALF_W      = SCREEN_WIDTH_DEF / 2;
    localparam int HALF_H      = SCREEN_HEIGHT_DEF / 2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               zero_depth;
    } pixel_t;

    class projection_board;
        int            focal;
        int            offset;
        pixel_t        pending[$];
        int            errors;
        int            points;
        int            zero_hits;
        int            checked;
        int            atan_steps[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                          41, 20, 10, 5, 3, 1, 1, 0};

        function new();
            focal = FOCAL_RESET;
            offset = OFFSET_RESET;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FOCAL)
                focal = data & 16'h0FFF;
            else if (idx == REG_OFFSET)
                offset = data & 16'h7FFF;
        endfunction

        function int clamp(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return int'(v);
        endfunction

        function void sine_cosine(logic [15:0] angle, output int sn, output int cs);
            logic [15:0] a;
            logic [15:0] probe;
            bit          flip;
            int          x;
            int          y;
            int          z;
            int          dx;
            int          dy;
            a = angle;
            probe = a + 16'd16384;
            flip = probe[15];
            if (flip)
                a = a + 16'd32768;
            z = int'($signed(a));
            x = 19898;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_steps[i];
                end
                else
                begin
                    x += dx; y -= dy; z += atan_steps[i];
                end
            end
            if (flip)
            begin
                x = -x; y = -y;
            end
            cs = clamp(x);
            sn = clamp(y);
        endfunction

        function int blend(int a, int ca, int b, int cb);
            longint v;
            v = longint'(a) * ca + longint'(b) * cb + 16384;
            return int'(v >>> 15);
        endfunction

        function int to_screen(int c, int depth, int half);
            longint q;
            q = (longint'(c) * focal) / depth;
            return clamp(q + half);
        endfunction

        function void note_point(logic [95:0] d);
            int     x;
            int     y;
            int     z;
            int     t;
            int     s;
            int     c;
            int     depth;
            pixel_t e;
            x = int'($signed(d[15:0]));
            y = int'($signed(d[31:16]));
            z = int'($signed(d[47:32]));
            sine_cosine(d[63:48], s, c);
            t = blend(y, c, z, -s);
            z = blend(y, s, z, c);
            y = t;
            sine_cosine(d[79:64], s, c);
            t = blend(x, c, z, s);
            z = blend(x, -s, z, c);
            x = t;
            sine_cosine(d[95:80], s, c);
            t = blend(x, c, y, -s);
            y = blend(x, s, y, c);
            x = t;
            depth = z + offset;
            e.zero_depth = (depth == 0);
            e.screen_x = 0;
            e.screen_y = 0;
            if (depth != 0)
            begin
                e.screen_x = 16'(to_screen(x, depth, HALF_W));
                e.screen_y = 16'(to_screen(y, depth, HALF_H));
            end
            else
                zero_hits++;
            points++;
            pending.push_back(e);
        endfunction

        task report(string what);
            errors++;
            $display("ERROR %0t: %s", $time, what);
        endtask

        task check_pixel(logic [31:0] data, logic flag);
            pixel_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %h/%b", data, flag));
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.screen_x)
                report($sformatf("screen_x got %0d want %0d",
                                 $signed(data[15:0]), e.screen_x));
            if (data[31:16] !== e.screen_y)
                report($sformatf("screen_y got %0d want %0d",
                                 $signed(data[31:16]), e.screen_y));
            if (flag !== e.zero_depth)
                report($sformatf("zero_depth got %b want %b", flag, e.zero_depth));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [95:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [31:0]            m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    projection_board board;
    int              tx_idle;
    int              rx_stall;
    longint          cycles;

    rotate_project_point_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: stall at random, check every accepted transfer.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= rx_stall);
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_pixel(m_tdata, m_tuser[0]);
        end
    end

    function logic [95:0] pack_point(int px, int py, int pz, int ax, int ay, int az);
        return {16'(az), 16'(ay), 16'(ax), 16'(pz), 16'(py), 16'(px)};
    endfunction

    task send_point(logic [95:0] d);
        @(negedge clk);
        if ($urandom_range(99) < tx_idle)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = d;
        do @(posedge clk); while (!s_tready);
        board.note_point(d);
    endtask

    task write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Holds the input back until every outstanding result has come out.
    task drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task send_directed;
        send_point(pack_point(0, 0, 0, 0, 0, 0));
        send_point(pack_point(32767, 32767, 32767, 0, 0, 0));
        send_point(pack_point(-32768, -32768, -32768, 0, 0, 0));
        send_point(pack_point(32767, -32768, 0, 65535, 65535, 65535));
        send_point(pack_point(4096, 0, 0, 16384, 0, 0));
        send_point(pack_point(0, 4096, 0, 16384, 0, 0));
        send_point(pack_point(0, 0, 4096, 0, 16384, 0));
        send_point(pack_point(4096, 4096, 0, 0, 0, 32768));
        send_point(pack_point(4096, 4096, 4096, 49152, 49152, 49152));
        send_point(pack_point(-4096, 2048, -20480, 0, 0, 0));
        send_point(pack_point(0, 0, -20480, 0, 0, 0));
        send_point(pack_point(0, 0, -32768, 0, 0, 0));
        send_point(pack_point(1000, -1000, 0, 8192, 24576, 40960));
        send_point(pack_point(0, 0, 20480, 32768, 0, 0));
        send_point(pack_point(-1, 1, -1, 16383, 16385, 32767));
        send_point(pack_point(12000, -12000, 8000, 57344, 8192, 0));
    endtask

    task send_random(int count);
        int px;
        int py;
        int pz;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(1))
            begin
                px = $urandom_range(8192) - 4096;
                py = $urandom_range(8192) - 4096;
                pz = $urandom_range(8192) - 4096;
            end
            else
            begin
                px = $urandom;
                py = $urandom;
                pz = $urandom;
            end
            send_point(pack_point(px, py, pz, $urandom, $urandom, $urandom));
        end
    endtask

    initial
    begin
        board = new();
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FOCAL;
        cfg_data = '0;
        tx_idle = 0;
        rx_stall = 0;
        cycles = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_directed();
        send_random(400);
        drain();

        write_cfg(REG_FOCAL, 16'd1);
        write_cfg(REG_OFFSET, 16'd0);
        tx_idle = 70;
        send_directed();
        send_random(400);
        drain();

        write_cfg(REG_FOCAL, 16'd4095);
        write_cfg(REG_OFFSET, 16'd32767);
        write_cfg(8'd2, 16'd7);
        tx_idle = 0;
        rx_stall = 70;
        send_directed();
        send_random(400);
        drain();

        // Upper data bits are dropped, so this leaves focal length at zero.
        write_cfg(REG_FOCAL, 16'h1000);
        write_cfg(REG_OFFSET, 16'hFFFF);
        tx_idle = 13;
        rx_stall = 13;
        send_random(200);
        drain();

        write_cfg(REG_FOCAL, 16'($urandom_range(4095, 1)));
        write_cfg(REG_OFFSET, 16'($urandom_range(32767)));
        send_random(200);
        drain();

        $display("Covered %0d points, %0d with zero depth, %0d results checked,",
                 board.points, board.zero_hits, board.checked);
        $display("across five register settings and four flow-control mixes.");
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
